// ----- hw/rtl/tcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Track corridor matcher package
// Shared widths, codes and state type of the track corridor matcher.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 20;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int TOL_W      = 16;
  localparam int TOL2_W     = 2 * TOL_W;
  localparam int ROOT_W     = TOL_W;
  localparam int DIST_W     = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PT_W       = 3 * COORD_BITS;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_TOL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIT_TOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIT_ENTRY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIT_EXIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_CNT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_ALT,
    ST_PREP,
    ST_ROOT
  } state_t;

endpackage

// ----- hw/rtl/track_corridor_matcher.sv -----
// ----------------------------------------------------------------------------
// Track corridor matcher
// A write goes straight into the point memory and leaves the block idle. A
// query reduces the start offset modulo the point count, scans the points
// through the memory pipeline, reads the last point after a hit at point 0,
// and takes a square root, skipped when nothing hits. One query at a time;
// the scan uses the single memory read port. The receiver cannot stall.
// Reset restores the register defaults; the point memory is not cleared.
// ----------------------------------------------------------------------------
module track_corridor_matcher
  import tcm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [IDX_W-1:0]            point_index,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [IDX_W-1:0]            start_offset,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                        result_valid,
  output logic                        on_track,
  output logic [IDX_W-1:0]            track_index,
  output logic [DIST_W-1:0]           distance
);

  state_t state, state_next;

  logic [TOL_W-1:0]  track_tol, pit_tol;
  logic [IDX_W-1:0]  pit_entry, pit_exit;
  logic [CNT_W-1:0]  point_cnt;
  logic [TOL2_W-1:0] track_tol2, pit_tol2;

  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [PT_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;

  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic [CNT_W-1:0] nq;
  logic [IDX_W-1:0] nm1;
  logic [IDX_W-1:0] off_sh;
  logic [IDX_W-1:0] rem;
  logic [3:0]       mod_cnt;
  logic [CNT_W-1:0] mod_t;

  logic [IDX_W-1:0] iidx;
  logic [CNT_W-1:0] icnt, ecnt;
  logic             found;
  logic [SUM_W-1:0] best;
  logic [IDX_W-1:0] hidx;

  logic              p1_v, p1_alt;
  logic [IDX_W-1:0]  p1_idx;
  logic              p2_v, p2_alt;
  logic [IDX_W-1:0]  p2_idx;
  logic [TOL2_W-1:0] p2_tol2;
  logic [DIFF_W-1:0] p2_ax, p2_ay, p2_az;
  logic              p3_v, p3_alt;
  logic [IDX_W-1:0]  p3_idx;
  logic [TOL2_W-1:0] p3_tol2;
  logic [SQ_W-1:0]   p3_sx, p3_sy, p3_sz;
  logic              p4_v, p4_alt;
  logic [IDX_W-1:0]  p4_idx;
  logic [TOL2_W-1:0] p4_tol2;
  logic [SUM_W-1:0]  p4_sum;

  logic [TOL2_W-1:0] sq_v, sq_res, sq_bit, sq_t;

  logic scanning, eval_v, ev_norm, hit, stop, wrap, ecnt_inc, last, alt_done;
  logic issue_v, in_pit;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_tol <= TOL_W'(560);
      pit_tol   <= TOL_W'(560);
      pit_entry <= '0;
      pit_exit  <= '0;
      point_cnt <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRACK_TOL: track_tol <= cfg_data;
        REG_PIT_TOL:   pit_tol   <= cfg_data;
        REG_PIT_ENTRY: pit_entry <= cfg_data[IDX_W-1:0];
        REG_PIT_EXIT:  pit_exit  <= cfg_data[IDX_W-1:0];
        REG_POINT_CNT: point_cnt <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    track_tol2 <= TOL2_W'(track_tol) * TOL2_W'(track_tol);
    pit_tol2   <= TOL2_W'(pit_tol) * TOL2_W'(pit_tol);
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_WRITE) begin
      mem[point_index] <= {pos_z, pos_y, pos_x};
    end
    rd_data <= mem[rd_addr];
  end

  assign scanning = (state == ST_SCAN) || (state == ST_ALT);
  assign eval_v   = p4_v && scanning;
  assign hit      = p4_sum <= SUM_W'(p4_tol2);
  assign ev_norm  = eval_v && !p4_alt && (state == ST_SCAN);
  assign stop     = ev_norm && !hit && found;
  assign wrap     = ev_norm && hit && (p4_idx == '0);
  assign ecnt_inc = ev_norm && !stop;
  assign last     = (ecnt + CNT_W'(1)) == nq;
  assign alt_done = eval_v && p4_alt;
  assign issue_v  = (state == ST_SCAN) && (icnt < nq) && !wrap;
  assign rd_addr  = wrap ? nm1 : iidx;
  assign nm1      = IDX_W'(nq - CNT_W'(1));
  assign mod_t    = {rem, off_sh[IDX_W-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && command == CMD_QUERY) state_next = ST_MOD;
      ST_MOD:  if (mod_cnt == 4'(IDX_W - 1)) state_next = ST_SCAN;
      ST_SCAN: begin
        if (stop) state_next = ST_PREP;
        else if (wrap) state_next = ST_ALT;
        else if (ecnt_inc && last) state_next = ST_PREP;
      end
      ST_ALT:  if (alt_done) state_next = (ecnt == nq) ? ST_PREP : ST_SCAN;
      ST_PREP: state_next = ST_ROOT;
      ST_ROOT: if (sq_bit == '0 || !found) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && command == CMD_QUERY) begin
      qx      <= pos_x;
      qy      <= pos_y;
      qz      <= pos_z;
      off_sh  <= start_offset;
      rem     <= '0;
      mod_cnt <= '0;
      if (point_cnt == '0) nq <= CNT_W'(1);
      else if (point_cnt > CNT_W'(MAX_POINTS)) nq <= CNT_W'(MAX_POINTS);
      else nq <= point_cnt;
    end
    if (state == ST_MOD) begin
      mod_cnt <= mod_cnt + 4'd1;
      off_sh  <= off_sh << 1;
      if (mod_t >= nq) rem <= IDX_W'(mod_t - nq);
      else             rem <= IDX_W'(mod_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      if (state == ST_MOD && mod_cnt == 4'(IDX_W - 1)) begin
        iidx  <= (mod_t >= nq) ? IDX_W'(mod_t - nq) : IDX_W'(mod_t);
        icnt  <= '0;
        ecnt  <= '0;
        found <= 1'b0;
        best  <= '1;
        hidx  <= '0;
      end
      if (issue_v) begin
        icnt <= icnt + CNT_W'(1);
        iidx <= ((CNT_W'(iidx) + CNT_W'(1)) == nq) ? '0 : iidx + IDX_W'(1);
      end
      if (ecnt_inc) ecnt <= ecnt + CNT_W'(1);
      if (ev_norm && hit) begin
        found <= 1'b1;
        hidx  <= p4_idx;
        if (p4_sum < best) best <= p4_sum;
      end
      if (alt_done) begin
        if (p4_sum < best) begin
          best <= p4_sum;
          hidx <= nm1;
        end
        iidx <= (nq == CNT_W'(1)) ? '0 : IDX_W'(1);
        icnt <= ecnt;
      end
    end
  end

  always_comb begin
    if (pit_entry > pit_exit)      in_pit = (p1_idx < pit_exit) || (p1_idx > pit_entry);
    else if (pit_entry < pit_exit) in_pit = (p1_idx > pit_entry) && (p1_idx < pit_exit);
    else                           in_pit = 1'b0;
    dx = DIFF_W'(qx) - DIFF_W'($signed(rd_data[COORD_BITS-1:0]));
    dy = DIFF_W'(qy) - DIFF_W'($signed(rd_data[2*COORD_BITS-1:COORD_BITS]));
    dz = DIFF_W'(qz) - DIFF_W'($signed(rd_data[3*COORD_BITS-1:2*COORD_BITS]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p1_v <= (state == ST_SCAN) && (issue_v || wrap);
      p2_v <= p1_v && scanning && !wrap;
      p3_v <= p2_v && scanning && !wrap;
      p4_v <= p3_v && scanning && !wrap;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx  <= rd_addr;
    p1_alt  <= wrap;
    p2_idx  <= p1_idx;
    p2_alt  <= p1_alt;
    p2_tol2 <= in_pit ? pit_tol2 : track_tol2;
    p2_ax   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    p2_ay   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    p2_az   <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    p3_idx  <= p2_idx;
    p3_alt  <= p2_alt;
    p3_tol2 <= p2_tol2;
    p3_sx   <= SQ_W'(p2_ax) * SQ_W'(p2_ax);
    p3_sy   <= SQ_W'(p2_ay) * SQ_W'(p2_ay);
    p3_sz   <= SQ_W'(p2_az) * SQ_W'(p2_az);
    p4_idx  <= p3_idx;
    p4_alt  <= p3_alt;
    p4_tol2 <= p3_tol2;
    p4_sum  <= SUM_W'(p3_sx) + SUM_W'(p3_sy) + SUM_W'(p3_sz);
  end

  assign sq_t = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      sq_v   <= best[TOL2_W-1:0];
      sq_res <= '0;
      sq_bit <= TOL2_W'(1) << (TOL2_W - 2);
    end else if (state == ST_ROOT && sq_bit != '0) begin
      if (sq_v >= sq_t) begin
        sq_v   <= sq_v - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_ROOT) && (sq_bit == '0 || !found);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROOT) begin
      on_track    <= found;
      track_index <= found ? hidx : '0;
      distance    <= found ? DIST_W'(sq_res[ROOT_W-1:0]) : DIST_MAX;
    end
  end

endmodule

// ----- hw/rtl/tcm_checker.sv -----
// ----------------------------------------------------------------------------
// Track corridor matcher checker
// Port-level assertions on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module tcm_assertions
  import tcm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              command,
  input logic              result_valid,
  input logic              on_track,
  input logic [IDX_W-1:0]  track_index,
  input logic [DIST_W-1:0] distance
);

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !on_track) |-> (track_index == '0 && distance == DIST_MAX))
    else $error("miss result carries wrong index or distance");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_WRITE) |=> (!busy && !result_valid))
    else $error("point write caused activity");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind track_corridor_matcher tcm_assertions u_tcm_checker (.*);

// ----- dv/tcm_checker.sv -----
// ----------------------------------------------------------------------------
// Track corridor matcher checker
// Watches the item, configuration and result channels of the matcher. It
// keeps its own copy of the point store and the registers, predicts each
// query result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tcm_checker
  import tcm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         command,
  input  logic [IDX_W-1:0]             point_index,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [IDX_W-1:0]             start_offset,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         result_valid,
  input  logic                         on_track,
  input  logic [IDX_W-1:0]             track_index,
  input  logic [DIST_W-1:0]            distance,
  output int                           pending,
  output int                           fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              on;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dval;
  } match_t;

  logic signed [COORD_BITS-1:0] px [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py [MAX_POINTS];
  logic signed [COORD_BITS-1:0] pz [MAX_POINTS];
  logic [15:0] track_tol, pit_tol;
  logic [11:0] pit_entry, pit_exit;
  logic [12:0] point_cnt;
  match_t      match_q[$];

  function automatic longint unsigned axis_sq(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > 64'sd4194304) d = 64'sd4194304;
    return longint'(d) * longint'(d);
  endfunction

  function automatic longint unsigned range_sq(longint qx, longint qy, longint qz, int k);
    return axis_sq(qx, px[k]) + axis_sq(qy, py[k]) + axis_sq(qz, pz[k]);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit in_pit_window(int k);
    if (pit_entry > pit_exit) return (k < pit_exit) || (k > pit_entry);
    if (pit_entry < pit_exit) return (k < pit_exit) && (k > pit_entry);
    return 1'b0;
  endfunction

  function automatic match_t corridor_match(longint qx, longint qy, longint qz, int off);
    match_t r;
    int n, k;
    longint unsigned tol, d2, best, alt, root;
    bit hit;
    n = point_cnt;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    k = off % n;
    best = '1;
    hit = 0;
    r.idx = '0;
    for (int j = 0; j < n; j++) begin
      tol = in_pit_window(k) ? pit_tol : track_tol;
      d2 = range_sq(qx, qy, qz, k);
      if (d2 <= tol * tol) begin
        hit = 1;
        if (d2 < best) best = d2;
        r.idx = IDX_W'(k);
        if (k == 0) begin
          alt = range_sq(qx, qy, qz, n - 1);
          if (alt < best) begin
            r.idx = IDX_W'(n - 1);
            best = alt;
          end
        end
      end else if (hit) begin
        break;
      end
      k = (k + 1 == n) ? 0 : k + 1;
    end
    r.on = hit;
    if (hit) begin
      root = int_root(best);
      r.dval = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
    end else begin
      r.dval = DIST_MAX;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    match_t want;
    if (rst) begin
      track_tol <= 16'd560;
      pit_tol <= 16'd560;
      pit_entry <= '0;
      pit_exit <= '0;
      point_cnt <= 13'd1;
      match_q.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRACK_TOL: track_tol <= cfg_data;
          REG_PIT_TOL:   pit_tol <= cfg_data;
          REG_PIT_ENTRY: pit_entry <= cfg_data[11:0];
          REG_PIT_EXIT:  pit_exit <= cfg_data[11:0];
          REG_POINT_CNT: point_cnt <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (command == CMD_WRITE) begin
          px[point_index] <= pos_x;
          py[point_index] <= pos_y;
          pz[point_index] <= pos_z;
        end else begin
          match_q.push_back(corridor_match(pos_x, pos_y, pos_z, start_offset));
        end
      end
      if (result_valid) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result on_track=%0d index=%0d distance=%0d",
                   $time, on_track, track_index, distance);
          fail_count <= fail_count + 1;
        end else begin
          want = match_q.pop_front();
          if (want.on !== on_track || want.idx !== track_index ||
              want.dval !== distance) begin
            $display("%0t: mismatch expected on_track=%0d index=%0d distance=%0d",
                     $time, want.on, want.idx, want.dval);
            $display("%0t:          actual   on_track=%0d index=%0d distance=%0d",
                     $time, on_track, track_index, distance);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= match_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Track corridor matcher testbench
// Loads track loops into the point store and sends position queries near
// and away from the track under several tolerance, pit window and point
// count settings, with random gaps on the sender side.
// ----------------------------------------------------------------------------
module tb;
  import tcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic start, busy, command;
  logic [IDX_W-1:0] point_index, start_offset;
  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic result_valid, on_track;
  logic [IDX_W-1:0] track_index;
  logic [DIST_W-1:0] distance;
  int pending, fail_count;

  int tx[MAX_POINTS], ty[MAX_POINTS], tz[MAX_POINTS];
  int eff_n;
  bit quiet;

  track_corridor_matcher u_dut (.*);
  tcm_checker u_chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < 14) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_item(logic cmd, int idx, int x, int y, int z, int off);
    @(negedge clk);
    sender_gap();
    command = cmd;
    point_index = idx[IDX_W-1:0];
    pos_x = x[COORD_BITS-1:0];
    pos_y = y[COORD_BITS-1:0];
    pos_z = z[COORD_BITS-1:0];
    start_offset = off[IDX_W-1:0];
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    if ($urandom_range(99) < 14) repeat ($urandom_range(1, 4)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(int cnt, int ttol, int ptol, int entry, int exit_idx);
    wait_idle();
    write_reg(REG_TRACK_TOL, ttol);
    write_reg(REG_PIT_TOL, ptol);
    write_reg(REG_PIT_ENTRY, entry);
    write_reg(REG_PIT_EXIT, exit_idx);
    write_reg(REG_POINT_CNT, cnt);
    eff_n = (cnt == 0) ? 1 : (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
  endtask

  // Points go around a square loop so that the last point sits next to point 0.
  task automatic load_track();
    int step, side, cx, cy, s;
    step = (eff_n > 64) ? 60 : $urandom_range(150, 400);
    side = (eff_n * step) / 4 + 1;
    cx = $urandom_range(0, 400000) - 200000;
    cy = $urandom_range(0, 400000) - 200000;
    for (int k = 0; k < eff_n; k++) begin
      s = (k * step) % (4 * side);
      if (s < side) begin
        tx[k] = cx + s; ty[k] = cy;
      end else if (s < 2 * side) begin
        tx[k] = cx + side; ty[k] = cy + s - side;
      end else if (s < 3 * side) begin
        tx[k] = cx + 3 * side - s; ty[k] = cy + side;
      end else begin
        tx[k] = cx; ty[k] = cy + 4 * side - s;
      end
      tz[k] = $urandom_range(0, 64) - 32;
      send_item(CMD_WRITE, k, tx[k], ty[k], tz[k], $urandom_range(0, 4095));
      if (eff_n < MAX_POINTS && $urandom_range(99) < 5)
        send_item(CMD_WRITE, $urandom_range(eff_n, 4095), $urandom, $urandom, $urandom,
                  $urandom_range(0, 4095));
    end
  endtask

  task automatic near_query(int amp);
    int k;
    k = $urandom_range(0, eff_n - 1);
    if ($urandom_range(3) == 0) amp = 0;
    send_item(CMD_QUERY, $urandom_range(0, 4095),
              tx[k] + $urandom_range(0, 2 * amp) - amp,
              ty[k] + $urandom_range(0, 2 * amp) - amp,
              tz[k] + $urandom_range(0, 2 * amp) - amp, $urandom_range(0, 4095));
  endtask

  task automatic run_phase(int cnt, int ttol, int ptol, int entry, int exit_idx,
                           int nq, bit calm);
    configure(cnt, ttol, ptol, entry, exit_idx);
    load_track();
    quiet = calm;
    for (int q = 0; q < nq; q++) begin
      if (q == nq / 2) wait_idle();
      if ($urandom_range(99) < 15)
        send_item(CMD_QUERY, $urandom_range(0, 4095), $urandom, $urandom, $urandom,
                  $urandom_range(0, 4095));
      else
        near_query($urandom_range(50, 700));
    end
    quiet = 1'b0;
  endtask

  initial begin
    int tt;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_WRITE;
    point_index = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    start_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TRACK_TOL;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: eight points, a pit window that wraps past zero.
    configure(8, 560, 100, 5, 2);
    for (int k = 0; k < 8; k++) begin
      tx[k] = 1000 + 300 * k;
      ty[k] = (k == 7) ? 40 : 0;
      tz[k] = 0;
      send_item(CMD_WRITE, k, tx[k], ty[k], tz[k], 0);
    end
    tx[7] = 1010;
    send_item(CMD_WRITE, 7, 1010, 40, 0, 0);
    send_item(CMD_WRITE, 4095, 524287, 524287, 524287, 4095);
    send_item(CMD_QUERY, 0, 1900, 0, 0, 0);
    send_item(CMD_QUERY, 4095, -524288, -524288, -524288, 4095);
    send_item(CMD_QUERY, 0, 524287, 524287, 524287, 0);
    send_item(CMD_QUERY, 0, 1020, 30, 0, 4095);
    send_item(CMD_QUERY, 0, 1000, 5, 0, 6);
    send_item(CMD_QUERY, 0, 2500, 90, 0, 3);
    send_item(CMD_QUERY, 0, 1450, 0, 3, 1);
    send_item(CMD_QUERY, 0, 3100, 0, 0, 5);

    run_phase(1, 0, 65535, 0, 0, 6, 1'b0);
    run_phase(0, 0, 0, 4095, 4095, 4, 1'b0);
    run_phase(5, 560, 300, 1, 3, 10, 1'b0);
    run_phase(16, 65535, 0, 7, 7, 8, 1'b0);
    run_phase(20, 400, 800, 15, 4, 12, 1'b1);
    tt = $urandom_range(6, 14);
    run_phase(tt, $urandom_range(100, 900), $urandom_range(100, 900),
              $urandom_range(0, tt - 1), $urandom_range(0, tt - 1), 10, 1'b0);
    run_phase(12, 560, 560, 11, 0, 12, 1'b0);

    wait_idle();
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
